[rtl/core/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants for the text console writer
// Defaults for geometry, opcode and state codes, cell store request bundle.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;
	localparam int CELLS_DEF   = COLUMNS_DEF * ROWS_DEF;

	// linear position width: covers row * COLUMNS + col at the largest geometry
	localparam int LIN_W = 12;

	localparam logic [7:0] ATTR       = 8'h07;
	localparam logic [7:0] BLANK_CHAR = 8'h00;

	typedef enum logic [2:0] {
		OP_PRINT      = 3'd0,
		OP_NEWLINE    = 3'd1,
		OP_SET_CURSOR = 3'd2,
		OP_DEL_PREV   = 3'd3,
		OP_DEL_CUR    = 3'd4,
		OP_BLANK_RUN  = 3'd5,
		OP_CLEAR      = 3'd6,
		OP_READ       = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DEC,
		ST_COPY,
		ST_DRAIN,
		ST_FILL,
		ST_RDWAIT,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic             we;
		logic [LIN_W-1:0] waddr;
		logic [7:0]       wdata;
		logic [LIN_W-1:0] raddr;
	} ram_req_t;

endpackage

[rtl/core/tcw_ram.sv]
// ----------------------------------------------------------------------------
// tcw_ram: cell store
// One write and one registered read per cycle; holds the character byte only,
// the attribute byte is constant and added on read-out.
// ----------------------------------------------------------------------------
module tcw_ram #(
	parameter int DEPTH = tcw_pkg::CELLS_DEF
) (
	input  logic              clk,
	input  tcw_pkg::ram_req_t req,
	output logic [7:0]        rdata_q
);

	localparam int AW = $clog2(DEPTH);

	logic [7:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr[AW-1:0]] <= req.wdata;
		end
		rdata_q <= mem_q[req.raddr[AW-1:0]];
	end

endmodule

[rtl/core/text_console_writer.sv]
// ----------------------------------------------------------------------------
// text_console_writer: text-mode console engine
// Cell store of ROWS x COLUMNS cells plus cursor, driven by one opcode per item.
// ----------------------------------------------------------------------------
// Usage: an item (opcode and its fields) is taken at a rising edge with start
// high and busy low. busy stays high until the result has been shown; the
// result is on ok/cur_col/cur_row/cursor_linear/cell_data for exactly one
// cycle, marked by done. The receiver cannot stall; the result is simply
// presented for that one cycle.
// Print, newline, set cursor (no scroll), blank run of zero, any rejected op:
// decode, then the result. Read cell: decode, read wait, then the result.
// Work walks the store one cell per cycle through the single address counter
// and the one write port:
//   scroll (print wrap, newline, set cursor past the last row): the rows below
//     the top move up one row, then the last row is blanked
//   delete: the cells after the deleted one move back by one cell, then the
//     last cell is blanked; a deleted last cell is only blanked
//   blank run: run length cells, up to the end of the store; clear: all cells.
// Reset: the cursor goes to 0,0 and a clearing pass blanks the store, one cell
// per cycle, with busy high.
// ----------------------------------------------------------------------------
module text_console_writer #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  opcode,
	input  logic [7:0]  char_code,
	input  logic [6:0]  col,
	input  logic [4:0]  row,
	input  logic [10:0] blank_count,
	output logic        done,
	output logic        ok,
	output logic [6:0]  cur_col,
	output logic [4:0]  cur_row,
	output logic [10:0] cursor_linear,
	output logic [15:0] cell_data
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam int LW    = tcw_pkg::LIN_W;

	tcw_pkg::state_t state_q, state_d;
	tcw_pkg::op_t    op_q;
	tcw_pkg::ram_req_t ram_req;

	logic [7:0]    ch_q;
	logic [6:0]    c_q;
	logic [4:0]    r_q;
	logic [10:0]   cnt_q;
	logic [6:0]    cc_q;
	logic [4:0]    cr_q;
	logic          ok_q;
	logic [15:0]   data_q;
	logic [AW-1:0] ptr_q;
	logic [AW-1:0] wa_q;
	logic [AW-1:0] fill_q;
	logic          pend_q;
	logic          scroll_q;
	logic          lim_q;
	logic          init_q;
	logic [7:0]    rdata_q;

	// shared position unit
	logic [6:0]    sel_col;
	logic [4:0]    sel_row;
	logic [LW-1:0] lin;
	logic [AW-1:0] lin_a;
	logic          sel_valid;

	logic [6:0] dc;
	logic [4:0] dr;
	logic       wrap;
	logic       nr_ovf;
	logic       fill_last;

	// decode results
	tcw_pkg::state_t d_next;
	logic            d_ok;
	logic            d_we;
	logic [6:0]      d_cc;
	logic [4:0]      d_cr;
	logic [AW-1:0]   d_ptr;
	logic [AW-1:0]   d_fill;
	logic            d_scroll;
	logic            d_lim;

	tcw_ram #(
		.DEPTH(CELLS)
	) u_ram (
		.clk    (clk),
		.req    (ram_req),
		.rdata_q(rdata_q)
	);

	// cell to remove for the delete ops
	always_comb begin
		dc = cc_q;
		dr = cr_q;
		if (op_q == tcw_pkg::OP_DEL_PREV) begin
			if (cc_q == 7'd0) begin
				dc = 7'(COLUMNS - 1);
				dr = cr_q - 5'd1;
			end else begin
				dc = cc_q - 7'd1;
			end
		end
	end

	always_comb begin
		sel_col = cc_q;
		sel_row = cr_q;
		if (state_q == tcw_pkg::ST_DEC) begin
			unique case (op_q) inside
				tcw_pkg::OP_DEL_PREV, tcw_pkg::OP_DEL_CUR: begin
					sel_col = dc;
					sel_row = dr;
				end
				tcw_pkg::OP_BLANK_RUN, tcw_pkg::OP_READ: begin
					sel_col = c_q;
					sel_row = r_q;
				end
				default: begin
					sel_col = cc_q;
					sel_row = cr_q;
				end
			endcase
		end
	end

	assign lin       = LW'(sel_row) * LW'(COLUMNS) + LW'(sel_col);
	assign lin_a     = lin[AW-1:0];
	assign sel_valid = (8'(sel_col) < 8'(COLUMNS)) && (6'(sel_row) < 6'(ROWS));

	assign wrap      = (8'(cc_q) + 8'd1) >= 8'(COLUMNS);
	assign nr_ovf    = (6'(cr_q) + 6'd1) >= 6'(ROWS);
	assign fill_last = (ptr_q == AW'(CELLS - 1)) || (lim_q && cnt_q == 11'd1);

	always_comb begin
		d_next   = tcw_pkg::ST_RESP;
		d_ok     = 1'b1;
		d_we     = 1'b0;
		d_cc     = cc_q;
		d_cr     = cr_q;
		d_ptr    = '0;
		d_fill   = AW'(CELLS - COLUMNS);
		d_scroll = 1'b1;
		d_lim    = 1'b0;
		unique case (op_q) inside
			tcw_pkg::OP_PRINT: begin
				if (!sel_valid) begin
					d_ok = 1'b0;
				end else begin
					d_we = 1'b1;
					if (!wrap) begin
						d_cc = cc_q + 7'd1;
					end else if (!nr_ovf) begin
						d_cc = '0;
						d_cr = cr_q + 5'd1;
					end else begin
						d_cc   = '0;
						d_cr   = 5'(ROWS - 1);
						d_next = tcw_pkg::ST_COPY;
						d_ptr  = AW'(COLUMNS);
					end
				end
			end
			tcw_pkg::OP_NEWLINE: begin
				if (6'(cr_q) < 6'(ROWS)) begin
					d_cc = '0;
					if (!nr_ovf) begin
						d_cr = cr_q + 5'd1;
					end else begin
						d_cr   = 5'(ROWS - 1);
						d_next = tcw_pkg::ST_COPY;
						d_ptr  = AW'(COLUMNS);
					end
				end
			end
			tcw_pkg::OP_SET_CURSOR: begin
				if (6'(r_q) >= 6'(ROWS)) begin
					d_cc   = '0;
					d_cr   = 5'(ROWS - 1);
					d_next = tcw_pkg::ST_COPY;
					d_ptr  = AW'(COLUMNS);
				end else begin
					d_cc = c_q;
					d_cr = r_q;
				end
			end
			tcw_pkg::OP_DEL_PREV, tcw_pkg::OP_DEL_CUR: begin
				if (op_q == tcw_pkg::OP_DEL_PREV && cc_q == 7'd0 && cr_q == 5'd0) begin
					d_ok = 1'b0;
				end else if (!sel_valid) begin
					d_ok = 1'b0;
				end else begin
					d_cc     = dc;
					d_cr     = dr;
					d_scroll = 1'b0;
					d_fill   = AW'(CELLS - 1);
					if (lin_a != AW'(CELLS - 1)) begin
						d_next = tcw_pkg::ST_COPY;
						d_ptr  = lin_a + AW'(1);
					end else begin
						d_next = tcw_pkg::ST_FILL;
						d_ptr  = AW'(CELLS - 1);
					end
				end
			end
			tcw_pkg::OP_BLANK_RUN: begin
				if (!sel_valid) begin
					d_ok = 1'b0;
				end else if (cnt_q != 11'd0) begin
					d_next = tcw_pkg::ST_FILL;
					d_ptr  = lin_a;
					d_lim  = 1'b1;
				end
			end
			tcw_pkg::OP_CLEAR: begin
				d_next = tcw_pkg::ST_FILL;
				d_ptr  = '0;
			end
			default: begin
				if (!sel_valid) begin
					d_ok = 1'b0;
				end else begin
					d_next = tcw_pkg::ST_RDWAIT;
				end
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tcw_pkg::ST_IDLE:   if (start) state_d = tcw_pkg::ST_DEC;
			tcw_pkg::ST_DEC:    state_d = d_next;
			tcw_pkg::ST_COPY:   if (ptr_q == AW'(CELLS - 1)) state_d = tcw_pkg::ST_DRAIN;
			tcw_pkg::ST_DRAIN:  state_d = tcw_pkg::ST_FILL;
			tcw_pkg::ST_FILL: begin
				if (fill_last) state_d = init_q ? tcw_pkg::ST_IDLE : tcw_pkg::ST_RESP;
			end
			tcw_pkg::ST_RDWAIT: state_d = tcw_pkg::ST_RESP;
			tcw_pkg::ST_RESP:   state_d = tcw_pkg::ST_IDLE;
			default:            state_d = tcw_pkg::ST_IDLE;
		endcase
	end

	// outputs and store port
	always_comb begin
		ram_req.we    = 1'b0;
		ram_req.waddr = LW'(ptr_q);
		ram_req.wdata = tcw_pkg::BLANK_CHAR;
		ram_req.raddr = (state_q == tcw_pkg::ST_COPY) ? LW'(ptr_q) : lin;
		unique case (state_q)
			tcw_pkg::ST_DEC: begin
				ram_req.we    = d_we;
				ram_req.waddr = lin;
				ram_req.wdata = ch_q;
			end
			tcw_pkg::ST_COPY: begin
				ram_req.we    = pend_q;
				ram_req.waddr = LW'(wa_q);
				ram_req.wdata = rdata_q;
			end
			tcw_pkg::ST_DRAIN: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = LW'(wa_q);
				ram_req.wdata = rdata_q;
			end
			tcw_pkg::ST_FILL: begin
				ram_req.we = 1'b1;
			end
			default: begin
				ram_req.we = 1'b0;
			end
		endcase
	end

	assign busy          = state_q != tcw_pkg::ST_IDLE;
	assign done          = state_q == tcw_pkg::ST_RESP;
	assign ok            = ok_q;
	assign cur_col       = cc_q;
	assign cur_row       = cr_q;
	assign cursor_linear = lin[10:0];
	assign cell_data     = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcw_pkg::ST_FILL;
			init_q  <= 1'b1;
			ptr_q   <= '0;
			lim_q   <= 1'b0;
			pend_q  <= 1'b0;
			cc_q    <= '0;
			cr_q    <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				tcw_pkg::ST_DEC: begin
					cc_q   <= d_cc;
					cr_q   <= d_cr;
					ptr_q  <= d_ptr;
					lim_q  <= d_lim;
					pend_q <= 1'b0;
				end
				tcw_pkg::ST_COPY: begin
					pend_q <= 1'b1;
					ptr_q  <= ptr_q + AW'(1);
				end
				tcw_pkg::ST_DRAIN: begin
					ptr_q <= fill_q;
				end
				tcw_pkg::ST_FILL: begin
					ptr_q <= ptr_q + AW'(1);
					if (fill_last) init_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tcw_pkg::ST_IDLE && start) begin
			op_q  <= tcw_pkg::op_t'(opcode);
			ch_q  <= char_code;
			c_q   <= col;
			r_q   <= row;
			cnt_q <= blank_count;
		end
		if (state_q == tcw_pkg::ST_DEC) begin
			ok_q     <= d_ok;
			data_q   <= '0;
			scroll_q <= d_scroll;
			fill_q   <= d_fill;
		end
		if (state_q == tcw_pkg::ST_COPY) begin
			// destination trails the source by one row (scroll) or one cell (delete)
			wa_q <= scroll_q ? (ptr_q - AW'(COLUMNS)) : (ptr_q - AW'(1));
		end
		if (state_q == tcw_pkg::ST_FILL) begin
			cnt_q <= cnt_q - 11'd1;
		end
		if (state_q == tcw_pkg::ST_RDWAIT) begin
			data_q <= {tcw_pkg::ATTR, rdata_q};
		end
	end

`ifndef SYNTHESIS
	a_done_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("busy still high after result");

	a_accept_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == tcw_pkg::ST_DEC))
		else $error("accepted item not decoded");

	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> (6'(cr_q) < 6'(ROWS)))
		else $error("cursor row beyond last row");

	a_drain_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tcw_pkg::ST_DRAIN) |-> pend_q)
		else $error("drain without a pending copy");
`endif

endmodule

[sim/text_console_checker.sv]
// ----------------------------------------------------------------------------
// text_console_checker: result checker for the text console writer
// Watches the command and result ports, keeps its own copy of the cell store
// and cursor, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module text_console_checker #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [2:0]  opcode,
	input  logic [7:0]  char_code,
	input  logic [6:0]  col,
	input  logic [4:0]  row,
	input  logic [10:0] blank_count,
	input  logic        done,
	input  logic        ok,
	input  logic [6:0]  cur_col,
	input  logic [4:0]  cur_row,
	input  logic [10:0] cursor_linear,
	input  logic [15:0] cell_data,
	output int          fail_count,
	output int          n_pending,
	output int          n_checked
);

	localparam int          CELLS = COLUMNS * ROWS;
	localparam logic [15:0] BLANK = {tcw_pkg::ATTR, tcw_pkg::BLANK_CHAR};

	typedef struct packed {
		logic        ok;
		logic [6:0]  ccol;
		logic [4:0]  crow;
		logic [10:0] lin;
		logic [15:0] data;
	} console_reply_t;

	logic [15:0]    screen [CELLS];
	int             cur_c;
	int             cur_r;
	console_reply_t reply_q [$];

	function automatic void blank_screen();
		for (int i = 0; i < CELLS; i++)
			screen[i] = BLANK;
	endfunction

	function automatic bit in_screen(int c, int r);
		return c < COLUMNS && r < ROWS;
	endfunction

	// moving past the last row scrolls everything up one row
	function automatic void place_cursor(int c, int r);
		if (r >= ROWS) begin
			for (int i = 0; i < CELLS - COLUMNS; i++)
				screen[i] = screen[i + COLUMNS];
			for (int i = CELLS - COLUMNS; i < CELLS; i++)
				screen[i] = BLANK;
			cur_c = 0;
			cur_r = ROWS - 1;
		end else begin
			cur_c = c & 'h7f;
			cur_r = r & 'h1f;
		end
	endfunction

	function automatic console_reply_t console_apply(tcw_pkg::op_t op, logic [7:0] ch,
			int c, int r, int cnt);
		console_reply_t rep;
		bit             ok_bit;
		int             dc;
		int             dr;
		int             idx;
		int             span;
		logic [15:0]    data;
		ok_bit = 1'b1;
		data   = '0;
		case (op)
		tcw_pkg::OP_PRINT: begin
			if (!in_screen(cur_c, cur_r)) begin
				ok_bit = 1'b0;
			end else begin
				screen[cur_r * COLUMNS + cur_c] = {tcw_pkg::ATTR, ch};
				if (cur_c + 1 >= COLUMNS)
					place_cursor(0, cur_r + 1);
				else
					place_cursor(cur_c + 1, cur_r);
			end
		end
		tcw_pkg::OP_NEWLINE: begin
			if (cur_r < ROWS)
				place_cursor(0, cur_r + 1);
		end
		tcw_pkg::OP_SET_CURSOR: place_cursor(c, r);
		tcw_pkg::OP_DEL_PREV, tcw_pkg::OP_DEL_CUR: begin
			dc = cur_c;
			dr = cur_r;
			if (op == tcw_pkg::OP_DEL_PREV) begin
				if (cur_c == 0 && cur_r == 0) begin
					ok_bit = 1'b0;
				end else if (cur_c == 0) begin
					dc = COLUMNS - 1;
					dr = cur_r - 1;
				end else begin
					dc = cur_c - 1;
				end
			end
			if (ok_bit && !in_screen(dc, dr))
				ok_bit = 1'b0;
			if (ok_bit) begin
				for (int i = dr * COLUMNS + dc; i + 1 < CELLS; i++)
					screen[i] = screen[i + 1];
				screen[CELLS - 1] = BLANK;
				place_cursor(dc, dr);
			end
		end
		tcw_pkg::OP_BLANK_RUN: begin
			if (!in_screen(c, r)) begin
				ok_bit = 1'b0;
			end else begin
				idx  = r * COLUMNS + c;
				span = (cnt < CELLS - idx) ? cnt : CELLS - idx;
				for (int i = 0; i < span; i++)
					screen[idx + i] = BLANK;
			end
		end
		tcw_pkg::OP_CLEAR: blank_screen();
		tcw_pkg::OP_READ: begin
			if (!in_screen(c, r))
				ok_bit = 1'b0;
			else
				data = screen[r * COLUMNS + c];
		end
		endcase
		rep.ok   = ok_bit;
		rep.ccol = 7'(cur_c);
		rep.crow = 5'(cur_r);
		rep.lin  = 11'(cur_r * COLUMNS + cur_c);
		rep.data = data;
		return rep;
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		console_reply_t want;
		if (!arst_n) begin
			blank_screen();
			cur_c = 0;
			cur_r = 0;
			reply_q.delete();
			fail_count = 0;
			n_checked  = 0;
			n_pending <= 0;
		end else begin
			if (done) begin
				if (reply_q.size() == 0) begin
					$display("%0t: result with no item waiting: expected none, %s %0b pos %0d",
						$time, "actual ok", ok, cursor_linear);
					fail_count++;
				end else begin
					want = reply_q.pop_front();
					check_field("ok", int'(want.ok), int'(ok));
					check_field("cur_col", int'(want.ccol), int'(cur_col));
					check_field("cur_row", int'(want.crow), int'(cur_row));
					check_field("cursor_linear", int'(want.lin), int'(cursor_linear));
					check_field("cell_data", int'(want.data), int'(cell_data));
					n_checked++;
				end
			end
			if (start && !busy)
				reply_q.push_back(console_apply(tcw_pkg::op_t'(opcode), char_code,
					int'(col), int'(row), int'(blank_count)));
			n_pending <= reply_q.size();
		end
	end

endmodule

[sim/tb_text_console_writer.sv]
// ----------------------------------------------------------------------------
// tb_text_console_writer: testbench for the text console writer
// Directed edge cases, then scenes of typed text, edits, blank runs and random
// commands with random gaps; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_text_console_writer;

	localparam int COLS          = tcw_pkg::COLUMNS_DEF;
	localparam int ROWS_N        = tcw_pkg::ROWS_DEF;
	localparam int RANDOM_CMDS   = 1750;
	localparam int SETTLE_CYCLES = 2100;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        start       = 1'b0;
	logic [2:0]  opcode      = tcw_pkg::OP_PRINT;
	logic [7:0]  char_code   = '0;
	logic [6:0]  col         = '0;
	logic [4:0]  row         = '0;
	logic [10:0] blank_count = '0;
	logic        busy;
	logic        done;
	logic        ok;
	logic [6:0]  cur_col;
	logic [4:0]  cur_row;
	logic [10:0] cursor_linear;
	logic [15:0] cell_data;
	int          fail_count;
	int          n_pending;
	int          n_checked;
	int          cmds_sent = 0;

	text_console_writer dut (.*);

	text_console_checker u_checker (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic wait_all_replies();
		start <= 1'b0;
		@(posedge clk);
		while (n_pending != 0)
			@(posedge clk);
	endtask

	task automatic issue_cmd(tcw_pkg::op_t op, int ch, int c, int r, int cnt);
		if (cmds_sent % 400 == 399) begin
			wait_all_replies();
		end else if ((cmds_sent < 700 || cmds_sent >= 1000) && $urandom_range(0, 99) < 9) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6))
				@(posedge clk);
		end
		opcode      <= op;
		char_code   <= 8'(ch);
		col         <= 7'(c);
		row         <= 5'(r);
		blank_count <= 11'(cnt);
		start       <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		cmds_sent++;
	endtask

	initial begin
		int c;
		int r;
		int n;
		int pick;
		int base;
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;

		issue_cmd(tcw_pkg::OP_READ, 0, 0, 0, 0);
		issue_cmd(tcw_pkg::OP_DEL_PREV, 0, 0, 0, 0);          // delete at origin
		issue_cmd(tcw_pkg::OP_PRINT, 8'hff, 0, 0, 0);
		issue_cmd(tcw_pkg::OP_PRINT, 8'h00, 0, 0, 0);
		issue_cmd(tcw_pkg::OP_READ, 0, 0, 0, 0);
		issue_cmd(tcw_pkg::OP_SET_CURSOR, 0, COLS - 1, 0, 0);
		issue_cmd(tcw_pkg::OP_PRINT, 8'h41, 0, 0, 0);         // wraps to next row
		issue_cmd(tcw_pkg::OP_DEL_PREV, 0, 0, 0, 0);          // back across the row boundary
		issue_cmd(tcw_pkg::OP_SET_CURSOR, 0, 127, ROWS_N - 1, 0);
		issue_cmd(tcw_pkg::OP_PRINT, 8'h42, 0, 0, 0);
		issue_cmd(tcw_pkg::OP_DEL_CUR, 0, 0, 0, 0);
		issue_cmd(tcw_pkg::OP_DEL_PREV, 0, 0, 0, 0);
		issue_cmd(tcw_pkg::OP_SET_CURSOR, 0, COLS, 3, 0);
		issue_cmd(tcw_pkg::OP_DEL_PREV, 0, 0, 0, 0);          // previous cell is valid again
		issue_cmd(tcw_pkg::OP_SET_CURSOR, 0, COLS - 1, ROWS_N - 1, 0);
		issue_cmd(tcw_pkg::OP_PRINT, 8'h5a, 0, 0, 0);         // wrap on last row scrolls
		issue_cmd(tcw_pkg::OP_NEWLINE, 0, 0, 0, 0);
		issue_cmd(tcw_pkg::OP_SET_CURSOR, 0, 0, 31, 0);
		issue_cmd(tcw_pkg::OP_BLANK_RUN, 0, 0, 0, 0);
		issue_cmd(tcw_pkg::OP_BLANK_RUN, 0, COLS - 1, ROWS_N - 1, 2000);
		issue_cmd(tcw_pkg::OP_DEL_CUR, 0, 0, 0, 0);
		issue_cmd(tcw_pkg::OP_READ, 0, 127, 31, 0);
		issue_cmd(tcw_pkg::OP_BLANK_RUN, 0, COLS, 0, 5);
		issue_cmd(tcw_pkg::OP_CLEAR, 0, 0, 0, 0);
		issue_cmd(tcw_pkg::OP_READ, 0, COLS - 1, ROWS_N - 1, 0);
		wait_all_replies();

		base = cmds_sent;
		while (cmds_sent < base + RANDOM_CMDS) begin
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 3) == 0) begin
				r = ROWS_N - 1;
				c = COLS - $urandom_range(1, 12);
			end else begin
				r = $urandom_range(0, ROWS_N - 1);
				c = $urandom_range(0, COLS - 1);
			end
			if (pick < 45) begin
				// a run of text, now and then broken by a newline
				n = $urandom_range(1, 16);
				issue_cmd(tcw_pkg::OP_SET_CURSOR, 0, c, r, 0);
				repeat (n) begin
					if ($urandom_range(0, 15) == 0)
						issue_cmd(tcw_pkg::OP_NEWLINE, 0, 0, 0, 0);
					else
						issue_cmd(tcw_pkg::OP_PRINT, $urandom_range(0, 255), 0, 0, 0);
				end
				repeat ($urandom_range(1, 3))
					issue_cmd(tcw_pkg::OP_READ, 0, c + $urandom_range(0, n), r, 0);
			end else if (pick < 60) begin
				issue_cmd(tcw_pkg::OP_SET_CURSOR, 0, c, r, 0);
				repeat ($urandom_range(1, 3))
					issue_cmd($urandom_range(0, 1) ? tcw_pkg::OP_DEL_PREV
						: tcw_pkg::OP_DEL_CUR, 0, 0, 0, 0);
				issue_cmd(tcw_pkg::OP_READ, 0, c, r, 0);
				issue_cmd(tcw_pkg::OP_READ, 0, (c == 0) ? 0 : c - 1, r, 0);
			end else if (pick < 70) begin
				// mostly short runs, a few long ones that hit the end of the store
				n = $urandom_range(0, 19);
				if (n == 0)
					n = 2000;
				else if (n < 4)
					n = $urandom_range(41, 2000);
				else
					n = $urandom_range(0, 40);
				issue_cmd(tcw_pkg::OP_BLANK_RUN, 0, c, r, n);
				issue_cmd(tcw_pkg::OP_READ, 0, c, r, 0);
				issue_cmd(tcw_pkg::OP_READ, 0, c + 1, r, 0);
			end else if (pick < 95) begin
				repeat ($urandom_range(1, 4))
					issue_cmd(tcw_pkg::op_t'($urandom_range(0, 7)), $urandom_range(0, 255),
						$urandom_range(0, 127), $urandom_range(0, 31),
						$urandom_range(0, 2000));
			end else begin
				// cursor parked past the right edge of a valid row
				issue_cmd(tcw_pkg::OP_SET_CURSOR, 0, $urandom_range(COLS, 127), r, 0);
				case ($urandom_range(0, 3))
				0: issue_cmd(tcw_pkg::OP_PRINT, $urandom_range(0, 255), 0, 0, 0);
				1: issue_cmd(tcw_pkg::OP_DEL_PREV, 0, 0, 0, 0);
				2: issue_cmd(tcw_pkg::OP_DEL_CUR, 0, 0, 0, 0);
				default: issue_cmd(tcw_pkg::OP_NEWLINE, 0, 0, 0, 0);
				endcase
			end
		end

		wait_all_replies();
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		$display("Sent %0d items, %0d results checked: edge cases, typed text with wrap",
			cmds_sent, n_checked);
		$display("and scroll, deletes, blank runs, clears, reads, random commands and gaps.");
		if (fail_count == 0 && n_pending == 0)
			$display("tb_text_console_writer: PASS");
		else
			$display("tb_text_console_writer: FAIL");
		$finish;
	end

	initial begin
		#200000000;
		$display("tb_text_console_writer: FAIL");
		$finish;
	end

endmodule

[text_console_writer.f]
rtl/core/tcw_pkg.sv
rtl/core/tcw_ram.sv
rtl/core/text_console_writer.sv
sim/text_console_checker.sv
sim/tb_text_console_writer.sv
